@@ sv/sst_pkg.sv @@
package sst_pkg;

   // Number of entries the table can hold
   localparam int CAPACITY = 64;
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 32;

   // Request codes; the unused code behaves as a query
   localparam logic [1:0] REQ_QUERY  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [VAL_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic             was_member;
      logic             status;
      logic [CNT_W-1:0] count_after;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL
   } cell_cmd_type;

   // Broadcast to every cell
   typedef struct packed {
      cell_cmd_type            cmd;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } cell_ctrl_type;

   // Compare results from one cell
   typedef struct packed {
      logic above;
      logic match;
   } cell_stat_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

endpackage

@@ sv/sst_cell.sv @@
module sst_cell
   import sst_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic signed [VAL_W-1:0] left_data,
   input  logic                    left_above,
   input  logic signed [VAL_W-1:0] right_data,
   output logic signed [VAL_W-1:0] data,
   output cell_stat_type           stat
);

   logic signed [VAL_W-1:0] data_ff;
   logic signed [VAL_W-1:0] data_in;
   logic                    occupied;

   // Slot holds a live entry when its index is below the count
   assign occupied   = CNT_W'(IDX) < ctrl.count;
   assign stat.above = occupied && (data_ff >= ctrl.value);
   assign stat.match = occupied && (data_ff == ctrl.value);
   assign data       = data_ff;

   // Insert shifts larger entries up; remove pulls them down
   always_comb begin
      case (ctrl.cmd)
         CELL_INS: begin
            if (left_above) begin
               data_in = left_data;
            end else if (stat.above || !occupied) begin
               data_in = ctrl.value;
            end else begin
               data_in = data_ff;
            end
         end
         CELL_DEL: begin
            data_in = stat.above ? right_data : data_ff;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ sv/sorted_set_table_core.sv @@
// Sorted set table: keeps up to 64 distinct signed 32-bit values in
// ascending order in a row of cells, one value per cell.
//
// Request channel: drive req_payload and raise start; the request is taken
// on a clock edge where start is high and busy is low. Codes: query,
// insert, remove (the unused code acts as a query).
//
// Response channel: rsp_valid is high for exactly one cycle with
// rsp_payload (was_member, status, count_after). The receiver cannot stall.
//
// Timing: taking a request registers it and moves the control to EXEC.
// In EXEC every cell compares the broadcast value, and on an insert or
// remove the entries from the affected place upward shift by one place at
// once; rsp_valid and the response are registered from EXEC. busy is high
// in EXEC, so no new request is taken until the last one has executed.
//
// Reset (synchronous, active high) empties the set and drops any request
// in flight. Cell contents are not cleared; only slots below the count are
// ever looked at.
module sorted_set_table_core
   import sst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   ctrl_state_type  state_ff, state_in;
   req_payload_type req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   cell_ctrl_type           ctrl;
   logic signed [VAL_W-1:0] cell_data  [CAPACITY];
   cell_stat_type           cell_stat  [CAPACITY];
   logic [CAPACITY-1:0]     match_vec;
   logic                    hit;
   logic                    full;
   logic                    exec;

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_data;
      logic                    left_above;
      logic signed [VAL_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data  = cell_data[i];
         assign left_above = 1'b0;
      end else begin : g_mid
         assign left_data  = cell_data[i-1];
         assign left_above = cell_stat[i-1].above;
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_body
         assign right_data = cell_data[i+1];
      end

      sst_cell #(
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .left_above (left_above),
         .right_data (right_data),
         .data       (cell_data[i]),
         .stat       (cell_stat[i])
      );

      assign match_vec[i] = cell_stat[i].match;
   end

   assign hit  = |match_vec;
   assign full = count_ff == CNT_W'(CAPACITY);
   assign exec = state_ff == ST_EXEC;

   // Cell command and next count
   always_comb begin
      ctrl.value = req_ff.value;
      ctrl.count = count_ff;
      ctrl.cmd   = CELL_HOLD;
      count_in   = count_ff;
      if (exec) begin
         if (req_ff.req_type == REQ_INSERT && !hit && !full) begin
            ctrl.cmd = CELL_INS;
            count_in = count_ff + 1'b1;
         end else if (req_ff.req_type == REQ_REMOVE && hit) begin
            ctrl.cmd = CELL_DEL;
            count_in = count_ff - 1'b1;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine
   always_comb begin
      busy = 1'b0;
      unique case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_EXEC: busy = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   // Response fields
   always_comb begin
      rsp_in.was_member  = hit;
      rsp_in.status      = (req_ff.req_type == REQ_INSERT) && !hit && full;
      rsp_in.count_after = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= exec;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_payload;
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ test/tb_sorted_set_table_core.sv @@
module tb_sorted_set_table_core;
   import sst_pkg::*;

   localparam logic [1:0]       REQ_UNUSED  = 2'd3;  // spare code, behaves as a query
   localparam logic [VAL_W-1:0] MIN_VAL     = 32'h8000_0000;
   localparam logic [VAL_W-1:0] MAX_VAL     = 32'h7FFF_FFFF;
   localparam int               CYCLE_LIMIT = 400000;
   localparam int               DRAIN_WAIT  = 8;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   rsp_payload_type rsp_payload;

   req_payload_type         pending_reqs[$];
   rsp_payload_type         expected_rsps[$];
   logic signed [VAL_W-1:0] held_values[$];   // predicted set contents, ascending
   logic [VAL_W-1:0]        recent_vals[$];   // values offered for insert so far
   int                      sender_idle_pct = 0;
   int                      mismatch_count  = 0;
   int                      cycle_count     = 0;
   int                      rand_index      = 0;

   sorted_set_table_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Set predictor: find the first entry not below the value, then update
   function automatic rsp_payload_type apply_request(req_payload_type r);
      rsp_payload_type         rsp;
      logic signed [VAL_W-1:0] v;
      int                      pos;
      logic                    hit;
      v   = r.value;
      pos = held_values.size();
      hit = 1'b0;
      for (int i = 0; i < held_values.size(); i++) begin
         if (held_values[i] >= v) begin
            pos = i;
            hit = (held_values[i] == v);
            break;
         end
      end
      rsp.was_member = hit;
      rsp.status     = 1'b0;
      if (r.req_type == REQ_INSERT && !hit) begin
         if (held_values.size() >= CAPACITY)
            rsp.status = 1'b1;
         else
            held_values.insert(pos, v);
      end else if (r.req_type == REQ_REMOVE && hit) begin
         held_values.delete(pos);
      end
      rsp.count_after = CNT_W'(held_values.size());
      return rsp;
   endfunction

   task automatic push_req(logic [1:0] kind, logic [VAL_W-1:0] v);
      req_payload_type r;
      r.req_type = kind;
      r.value    = v;
      pending_reqs.push_back(r);
      if (kind == REQ_INSERT)
         recent_vals.push_back(v);
   endtask

   // Mix of wide random values, small values and values near the extremes
   function automatic logic [VAL_W-1:0] fresh_value();
      case ($urandom_range(3))
         0, 1: return $urandom;
         2: return 32'($urandom_range(64)) - 32'd32;
         default: begin
            if ($urandom_range(1))
               return MAX_VAL - 32'($urandom_range(15));
            else
               return MIN_VAL + 32'($urandom_range(15));
         end
      endcase
   endfunction

   // Pick one of the last hundred insert values, so lookups tend to hit
   function automatic logic [VAL_W-1:0] recent_value();
      int lo;
      if (recent_vals.size() == 0)
         return fresh_value();
      lo = (recent_vals.size() > 100) ? recent_vals.size() - 100 : 0;
      return recent_vals[$urandom_range(recent_vals.size() - 1, lo)];
   endfunction

   // Alternating grow and shrink bursts; grow runs long enough to fill the set
   task automatic gen_random(int n);
      logic [1:0]       kind;
      logic [VAL_W-1:0] v;
      int               roll;
      logic             grow;
      for (int k = 0; k < n; k++) begin
         grow = (rand_index % 200) < 120;
         rand_index++;
         roll = $urandom_range(99);
         if (roll < 8) begin
            kind = 2'($urandom_range(3));
            v    = $urandom;
         end else if (grow) begin
            roll = $urandom_range(99);
            if (roll < 80)
               kind = REQ_INSERT;
            else if (roll < 90)
               kind = REQ_QUERY;
            else if (roll < 97)
               kind = REQ_REMOVE;
            else
               kind = REQ_UNUSED;
            if (kind == REQ_INSERT && $urandom_range(99) < 70)
               v = fresh_value();
            else
               v = recent_value();
         end else begin
            roll = $urandom_range(99);
            if (roll < 75)
               kind = REQ_REMOVE;
            else if (roll < 88)
               kind = REQ_QUERY;
            else if (roll < 96)
               kind = REQ_INSERT;
            else
               kind = REQ_UNUSED;
            v = ($urandom_range(99) < 85) ? recent_value() : fresh_value();
         end
         push_req(kind, v);
      end
   endtask

   // Poll on the falling edge so the driver's updates have settled
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
   endtask

   task automatic check_response(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_rsps.size() == 0) begin
         $error("unexpected response: was_member %0d status %0d count_after %0d",
                got.was_member, got.status, got.count_after);
         mismatch_count++;
      end else begin
         want = expected_rsps.pop_front();
         if (got.was_member !== want.was_member) begin
            $error("was_member: expected %0d, actual %0d", want.was_member, got.was_member);
            mismatch_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
         end
         if (got.count_after !== want.count_after) begin
            $error("count_after: expected %0d, actual %0d",
                   want.count_after, got.count_after);
            mismatch_count++;
         end
      end
   endtask

   // Request driver: predict on acceptance, then offer the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start)
            expected_rsps.push_back(apply_request(req_payload));
         if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start       <= 1'b1;
            req_payload <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         check_response(rsp_payload);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty set, extremes, duplicates, spare code, removes at each end
      push_req(REQ_QUERY, 32'd0);
      push_req(REQ_REMOVE, 32'd5);
      push_req(REQ_INSERT, MIN_VAL);
      push_req(REQ_INSERT, MAX_VAL);
      push_req(REQ_INSERT, 32'd0);
      push_req(REQ_INSERT, 32'hFFFF_FFFF);
      push_req(REQ_INSERT, 32'd1);
      push_req(REQ_INSERT, 32'd0);
      push_req(REQ_QUERY, MAX_VAL);
      push_req(REQ_QUERY, 32'd7);
      push_req(REQ_UNUSED, 32'hFFFF_FFFF);
      push_req(REQ_UNUSED, 32'd12345);
      push_req(REQ_INSERT, 32'h7FFF_FFFE);
      push_req(REQ_INSERT, 32'h8000_0001);
      push_req(REQ_INSERT, 32'h5555_5555);
      push_req(REQ_INSERT, 32'hAAAA_AAAA);
      push_req(REQ_REMOVE, 32'd1);
      push_req(REQ_REMOVE, MIN_VAL);
      push_req(REQ_REMOVE, MAX_VAL);
      push_req(REQ_REMOVE, 32'd99);
      push_req(REQ_QUERY, MIN_VAL);
      push_req(REQ_QUERY, 32'hAAAA_AAAA);
      wait_drained();

      // Random phases with different sender idle rates
      sender_idle_pct = 0;
      gen_random(270);
      wait_drained();
      sender_idle_pct = 86;
      gen_random(270);
      wait_drained();
      sender_idle_pct = 0;
      gen_random(270);
      wait_drained();
      sender_idle_pct = 31;
      gen_random(270);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sorted_set_table_core.f @@
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sorted_set_table_core.sv
test/tb_sorted_set_table_core.sv
